>>> rtl/core/mm3_pkg.sv
// Shared types, constants and micro-program tables for the MurmurHash3 x64_128 block.
package mm3_pkg;

   // Hash constants
   localparam logic [63:0] C1_VALUE   = 64'h87c37b91114253d5;
   localparam logic [63:0] C2_VALUE   = 64'h4cf5ad432745937f;
   localparam logic [63:0] F1_VALUE   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] F2_VALUE   = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] ADD1_VALUE = 64'h0000000052dce729;
   localparam logic [63:0] ADD2_VALUE = 64'h0000000038495ab5;

   localparam int          COUNT_W    = 31;
   localparam logic [30:0] COUNT_MAX  = 31'h7fffffff;

   // Word layout on the stream ports
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 128;
   localparam int SEED_W     = 32;

   // Micro-program lengths
   localparam int STEP_W          = 5;
   localparam logic [4:0] SCR_LAST_STEP = 5'd12;
   localparam logic [4:0] FIN_LAST_STEP = 5'd19;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_ROT,
      OP_XOR_LANES,
      OP_MIX1,
      OP_MIX2,
      OP_FIN_LOAD,
      OP_ADD1,
      OP_ADD2,
      OP_SHX,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      K_C1,
      K_C2,
      K_F1,
      K_F2
   } konst_type;

   typedef enum logic {
      SEL_ONE,
      SEL_TWO
   } sel_type;

   // Command from controller to datapath
   typedef struct packed {
      op_type    op;
      sel_type   sel;
      konst_type konst;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_last;
      logic is_full;
   } status_type;

   function automatic logic [63:0] konst_value(konst_type k);
      logic [63:0] v;
      case (k)
         K_C1:    v = C1_VALUE;
         K_C2:    v = C2_VALUE;
         K_F1:    v = F1_VALUE;
         K_F2:    v = F2_VALUE;
         default: v = C1_VALUE;
      endcase
      return v;
   endfunction

   function automatic cmd_type mk_cmd(op_type op, sel_type sel, konst_type konst);
      cmd_type c;
      c.op    = op;
      c.sel   = sel;
      c.konst = konst;
      return c;
   endfunction

   // Scramble both key words: k1*C1, k2*C2, rotate, k1*C2, k2*C1
   function automatic cmd_type scr_cmd(logic [4:0] step);
      cmd_type c;
      case (step)
         5'd0:    c = mk_cmd(OP_MUL0, SEL_ONE, K_C1);
         5'd1:    c = mk_cmd(OP_MUL1, SEL_ONE, K_C1);
         5'd2:    c = mk_cmd(OP_MUL2, SEL_ONE, K_C1);
         5'd3:    c = mk_cmd(OP_MUL0, SEL_TWO, K_C2);
         5'd4:    c = mk_cmd(OP_MUL1, SEL_TWO, K_C2);
         5'd5:    c = mk_cmd(OP_MUL2, SEL_TWO, K_C2);
         5'd6:    c = mk_cmd(OP_ROT,  SEL_ONE, K_C1);
         5'd7:    c = mk_cmd(OP_MUL0, SEL_ONE, K_C2);
         5'd8:    c = mk_cmd(OP_MUL1, SEL_ONE, K_C2);
         5'd9:    c = mk_cmd(OP_MUL2, SEL_ONE, K_C2);
         5'd10:   c = mk_cmd(OP_MUL0, SEL_TWO, K_C1);
         5'd11:   c = mk_cmd(OP_MUL1, SEL_TWO, K_C1);
         5'd12:   c = mk_cmd(OP_MUL2, SEL_TWO, K_C1);
         default: c = mk_cmd(OP_NOP,  SEL_ONE, K_C1);
      endcase
      return c;
   endfunction

   // Finalisation: length xor, lane adds, fmix64 on both, lane adds
   function automatic cmd_type fin_cmd(logic [4:0] step);
      cmd_type c;
      case (step)
         5'd0:    c = mk_cmd(OP_FIN_LOAD, SEL_ONE, K_F1);
         5'd1:    c = mk_cmd(OP_ADD1, SEL_ONE, K_F1);
         5'd2:    c = mk_cmd(OP_ADD2, SEL_ONE, K_F1);
         5'd3:    c = mk_cmd(OP_SHX,  SEL_ONE, K_F1);
         5'd4:    c = mk_cmd(OP_MUL0, SEL_ONE, K_F1);
         5'd5:    c = mk_cmd(OP_MUL1, SEL_ONE, K_F1);
         5'd6:    c = mk_cmd(OP_MUL2, SEL_ONE, K_F1);
         5'd7:    c = mk_cmd(OP_MUL0, SEL_TWO, K_F1);
         5'd8:    c = mk_cmd(OP_MUL1, SEL_TWO, K_F1);
         5'd9:    c = mk_cmd(OP_MUL2, SEL_TWO, K_F1);
         5'd10:   c = mk_cmd(OP_SHX,  SEL_ONE, K_F2);
         5'd11:   c = mk_cmd(OP_MUL0, SEL_ONE, K_F2);
         5'd12:   c = mk_cmd(OP_MUL1, SEL_ONE, K_F2);
         5'd13:   c = mk_cmd(OP_MUL2, SEL_ONE, K_F2);
         5'd14:   c = mk_cmd(OP_MUL0, SEL_TWO, K_F2);
         5'd15:   c = mk_cmd(OP_MUL1, SEL_TWO, K_F2);
         5'd16:   c = mk_cmd(OP_MUL2, SEL_TWO, K_F2);
         5'd17:   c = mk_cmd(OP_SHX,  SEL_ONE, K_F2);
         5'd18:   c = mk_cmd(OP_ADD1, SEL_ONE, K_F2);
         5'd19:   c = mk_cmd(OP_ADD2, SEL_ONE, K_F2);
         default: c = mk_cmd(OP_NOP,  SEL_ONE, K_F1);
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/mm3_datapath.sv
// Datapath: lanes, key words, shared 32x32 multiplier, byte count and result register.
module mm3_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mm3_pkg::cmd_type                   cmd,
   output mm3_pkg::status_type                status,
   input  logic [mm3_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   input  logic                               csr_valid,
   input  logic [mm3_pkg::SEED_W-1:0]         csr_data,
   output logic [mm3_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);

   logic [63:0] lane1_ff, lane1_in;
   logic [63:0] lane2_ff, lane2_in;
   logic [63:0] k1_ff, k1_in;
   logic [63:0] k2_ff, k2_in;
   logic [63:0] prod_ff, prod_in;
   logic [30:0] count_ff, count_in;
   logic        sat_ff, sat_in;
   logic        last_ff, last_in;
   logic        full_ff, full_in;
   logic [31:0] seed_ff;
   logic [63:0] hash1_ff, hash1_in;
   logic [63:0] hash2_ff, hash2_in;
   logic        ovf_ff, ovf_in;

   // Byte mask: low n bytes kept
   function automatic logic [63:0] byte_mask(logic [4:0] n);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (n > 5'(i)) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

   // Incoming word decode
   logic [63:0] blk_lo, blk_hi;
   logic [4:0]  vb_raw, vb, vb_hi;
   logic        full_blk;
   logic [63:0] lo_mask, hi_mask;
   logic [4:0]  add_bytes;
   logic [31:0] count_sum;

   always_comb begin
      blk_lo    = req_tdata[63:0];
      blk_hi    = req_tdata[127:64];
      vb_raw    = req_tdata[132:128];
      vb        = (vb_raw > 5'd16) ? 5'd16 : vb_raw;
      vb_hi     = (vb > 5'd8) ? (vb - 5'd8) : 5'd0;
      full_blk  = !req_tlast || (vb == 5'd16);
      lo_mask   = full_blk ? {64{1'b1}} : byte_mask(vb);
      hi_mask   = full_blk ? {64{1'b1}} : byte_mask(vb_hi);
      add_bytes = req_tlast ? vb : 5'd16;
      count_sum = {1'b0, count_ff} + {27'd0, add_bytes};
   end

   // Shared multiplier: one 32x32 partial product per cycle, low 64 bits kept
   logic [63:0] mul_a, mul_b;
   logic [31:0] pp_a, pp_b;
   logic [63:0] pp;

   always_comb begin
      mul_a = (cmd.sel == mm3_pkg::SEL_TWO) ? k2_ff : k1_ff;
      mul_b = mm3_pkg::konst_value(cmd.konst);
      pp_a  = (cmd.op == mm3_pkg::OP_MUL2) ? mul_a[63:32] : mul_a[31:0];
      pp_b  = (cmd.op == mm3_pkg::OP_MUL1) ? mul_b[63:32] : mul_b[31:0];
      pp    = {32'd0, pp_a} * {32'd0, pp_b};
   end

   // Lane mix terms
   logic [63:0] t1, r1, s1, t2, r2, s2, mul_done;

   always_comb begin
      t1 = lane1_ff ^ k1_ff;
      r1 = {t1[36:0], t1[63:37]};
      s1 = r1 + lane2_ff;
      t2 = lane2_ff ^ k2_ff;
      r2 = {t2[32:0], t2[63:33]};
      s2 = r2 + lane1_ff;
      mul_done = prod_ff + {pp[31:0], 32'd0};
   end

   // Operation decode
   always_comb begin
      lane1_in = lane1_ff;
      lane2_in = lane2_ff;
      k1_in    = k1_ff;
      k2_in    = k2_ff;
      prod_in  = prod_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      hash1_in = hash1_ff;
      hash2_in = hash2_ff;
      ovf_in   = ovf_ff;
      case (cmd.op)
         mm3_pkg::OP_LOAD: begin
            k1_in   = blk_lo & lo_mask;
            k2_in   = blk_hi & hi_mask;
            last_in = req_tlast;
            full_in = full_blk;
            if (count_sum[31]) begin
               count_in = mm3_pkg::COUNT_MAX;
               sat_in   = 1'b1;
            end else begin
               count_in = count_sum[30:0];
            end
         end
         mm3_pkg::OP_MUL0: prod_in = pp;
         mm3_pkg::OP_MUL1: prod_in = mul_done;
         mm3_pkg::OP_MUL2: begin
            if (cmd.sel == mm3_pkg::SEL_TWO) begin
               k2_in = mul_done;
            end else begin
               k1_in = mul_done;
            end
         end
         mm3_pkg::OP_ROT: begin
            k1_in = {k1_ff[32:0], k1_ff[63:33]};
            k2_in = {k2_ff[30:0], k2_ff[63:31]};
         end
         mm3_pkg::OP_XOR_LANES: begin
            lane1_in = t1;
            lane2_in = t2;
         end
         mm3_pkg::OP_MIX1: lane1_in = {s1[61:0], 2'b00} + s1 + mm3_pkg::ADD1_VALUE;
         mm3_pkg::OP_MIX2: lane2_in = {s2[61:0], 2'b00} + s2 + mm3_pkg::ADD2_VALUE;
         mm3_pkg::OP_FIN_LOAD: begin
            k1_in = lane1_ff ^ {33'd0, count_ff};
            k2_in = lane2_ff ^ {33'd0, count_ff};
         end
         mm3_pkg::OP_ADD1: k1_in = k1_ff + k2_ff;
         mm3_pkg::OP_ADD2: k2_in = k2_ff + k1_ff;
         mm3_pkg::OP_SHX: begin
            k1_in = k1_ff ^ {33'd0, k1_ff[63:33]};
            k2_in = k2_ff ^ {33'd0, k2_ff[63:33]};
         end
         mm3_pkg::OP_EMIT: begin
            hash1_in = k1_ff;
            hash2_in = k2_ff;
            ovf_in   = sat_ff;
            lane1_in = {32'd0, seed_ff};
            lane2_in = {32'd0, seed_ff};
            count_in = '0;
            sat_in   = 1'b0;
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lane1_ff <= '0;
         lane2_ff <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
         seed_ff  <= '0;
         last_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         lane1_ff <= lane1_in;
         lane2_ff <= lane2_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
         last_ff  <= last_in;
         full_ff  <= full_in;
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      prod_ff  <= prod_in;
      hash1_ff <= hash1_in;
      hash2_ff <= hash2_in;
      ovf_ff   <= ovf_in;
   end

   assign status.is_last = last_ff;
   assign status.is_full = full_ff;
   assign rsp_tdata      = {hash2_ff, hash1_ff};
   assign rsp_tuser      = ovf_ff;

endmodule

>>> rtl/core/mm3_ctrl.sv
// Controller: sequences the micro-program and owns both stream handshakes.
module mm3_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  mm3_pkg::status_type   status,
   output mm3_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_SCRAMBLE = 5'b00010,
      S_MIX      = 5'b00100,
      S_FINAL    = 5'b01000,
      S_EMIT     = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [mm3_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;
   logic                          mix_done;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   // Tail path needs one lane xor, a full block both mix steps, MIX1 then MIX2
   assign mix_done   = !status.is_full || (step_ff == 5'd1);

   // Next state and command
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = mm3_pkg::mk_cmd(mm3_pkg::OP_NOP, mm3_pkg::SEL_ONE, mm3_pkg::K_C1);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd      = mm3_pkg::mk_cmd(mm3_pkg::OP_LOAD, mm3_pkg::SEL_ONE,
                                          mm3_pkg::K_C1);
               state_in = S_SCRAMBLE;
               step_in  = '0;
            end
         end
         S_SCRAMBLE: begin
            cmd     = mm3_pkg::scr_cmd(step_ff);
            step_in = step_ff + 5'd1;
            if (step_ff == mm3_pkg::SCR_LAST_STEP) begin
               state_in = S_MIX;
               step_in  = '0;
            end
         end
         S_MIX: begin
            if (!status.is_full) begin
               cmd = mm3_pkg::mk_cmd(mm3_pkg::OP_XOR_LANES, mm3_pkg::SEL_ONE,
                                     mm3_pkg::K_C1);
            end else if (step_ff == 5'd0) begin
               cmd = mm3_pkg::mk_cmd(mm3_pkg::OP_MIX1, mm3_pkg::SEL_ONE, mm3_pkg::K_C1);
            end else begin
               cmd = mm3_pkg::mk_cmd(mm3_pkg::OP_MIX2, mm3_pkg::SEL_TWO, mm3_pkg::K_C1);
            end
            step_in = step_ff + 5'd1;
            if (mix_done) begin
               step_in  = '0;
               state_in = status.is_last ? S_FINAL : S_IDLE;
            end
         end
         S_FINAL: begin
            cmd     = mm3_pkg::fin_cmd(step_ff);
            step_in = step_ff + 5'd1;
            if (step_ff == mm3_pkg::FIN_LAST_STEP) begin
               state_in = S_EMIT;
               step_in  = '0;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd      = mm3_pkg::mk_cmd(mm3_pkg::OP_EMIT, mm3_pkg::SEL_ONE,
                                          mm3_pkg::K_C1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // Result word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == mm3_pkg::OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/murmur3_x64_128_hash.sv
// A non-last word is always mixed as a full block; the next word is taken once its scramble
// and mix steps are done and the controller is back in idle.
// A last word gives its result after scramble, mix (tail or full block), finalisation and emit.
// Throughput is set by the single shared 32x32 multiplier, one partial product at a time.
// The result register lets the next key start while a hash still waits to be taken.
// Top level of the MurmurHash3 x64_128 streaming hash; reset (synchronous, active high)
// clears lanes, byte count and seed to zero.
module murmur3_x64_128_hash (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, [135:133] zero
   input  logic [mm3_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [63:0] hash_first, [127:64] hash_second
   output logic [mm3_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] length_overflow
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mm3_pkg::SEED_W-1:0]         csr_data
);

   mm3_pkg::cmd_type    cmd;
   mm3_pkg::status_type status;

   // Seed register always takes a write
   assign csr_ready = 1'b1;

   mm3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mm3_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

`ifndef SYNTHESIS
   // Words are loaded only on an input handshake
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mm3_pkg::OP_LOAD) |-> (req_tvalid && req_tready))
      else $error("word loaded without handshake");

   // Block is busy the cycle after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready high right after accepting a word");

   // A hash is only written into a free result register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mm3_pkg::OP_EMIT) |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // Result valid only rises after an emit
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.op == mm3_pkg::OP_EMIT))
      else $error("result valid without emit");
`endif

endmodule

>>> tb/sv/murmur3_x64_128_hash_test.sv
// Self-checking testbench for the streaming MurmurHash3 x64_128 block.
module murmur3_x64_128_hash_test;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 48;    // covers the last-word latency
   localparam int RANDOM_WORDS = 1300;
   localparam int PLAN_ROWS    = 23;

   typedef struct packed {
      logic        ovf;
      logic [63:0] second;
      logic [63:0] first;
   } hash_type;

   typedef enum logic { ROW_WORD, ROW_SEED } row_kind_type;

   // One step of the directed plan: a key word, or a seed write (seed in lo)
   typedef struct packed {
      row_kind_type kind;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [4:0]   nbytes;
      logic         last;
      logic         pinned;
      hash_type     pin;
   } row_type;

   // Block ports
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, [135:133] zero
   logic [mm3_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [63:0] hash_first, [127:64] hash_second
   logic [mm3_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // [0] length_overflow
   logic                           rsp_tuser;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [mm3_pkg::SEED_W-1:0]     csr_data   = '0;

   // Typed-in expectation travelling with the word on the bus
   logic                           word_pin      = 1'b0;
   hash_type                       word_pin_hash = '0;

   // Predictor state
   logic [63:0]                    lane_h1   = '0;
   logic [63:0]                    lane_h2   = '0;
   logic [mm3_pkg::COUNT_W-1:0]    key_bytes = '0;
   logic                           key_capped = 1'b0;
   logic [mm3_pkg::SEED_W-1:0]     seed_now  = '0;

   hash_type              hash_due[$];
   int                    mismatches = 0;
   int                    cycles = 0;
   int                    long_hold_cycles = 0;
   bit                    no_gaps = 1'b0;

   murmur3_x64_128_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hash arithmetic
   function automatic logic [63:0] rotl64(logic [63:0] v, int s);
      return (v << s) | (v >> (64 - s));
   endfunction

   function automatic logic [63:0] mix_low(logic [63:0] k);
      logic [63:0] t;
      t = k * mm3_pkg::C1_VALUE;
      t = rotl64(t, 31);
      return t * mm3_pkg::C2_VALUE;
   endfunction

   function automatic logic [63:0] mix_high(logic [63:0] k);
      logic [63:0] t;
      t = k * mm3_pkg::C2_VALUE;
      t = rotl64(t, 33);
      return t * mm3_pkg::C1_VALUE;
   endfunction

   function automatic logic [63:0] fmix64(logic [63:0] v);
      logic [63:0] t;
      t = v ^ (v >> 33);
      t = t * mm3_pkg::F1_VALUE;
      t = t ^ (t >> 33);
      t = t * mm3_pkg::F2_VALUE;
      return t ^ (t >> 33);
   endfunction

   function automatic logic [63:0] tail_keep(int n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   // Fold one accepted word into the lanes; a last word queues its hash
   task automatic absorb_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] nbytes,
                              logic last, logic pinned, hash_type pin);
      int          n;
      logic [31:0] sum;
      logic [63:0] len64;
      logic [63:0] f1;
      logic [63:0] f2;
      hash_type    h;
      n = last ? ((nbytes > 5'd16) ? 16 : int'(nbytes)) : 16;
      if (n == 16) begin
         lane_h1 = lane_h1 ^ mix_low(lo);
         lane_h1 = rotl64(lane_h1, 27) + lane_h2;
         lane_h1 = lane_h1 * 64'd5 + mm3_pkg::ADD1_VALUE;
         lane_h2 = lane_h2 ^ mix_high(hi);
         lane_h2 = rotl64(lane_h2, 31) + lane_h1;
         lane_h2 = lane_h2 * 64'd5 + mm3_pkg::ADD2_VALUE;
      end else begin
         // tail path: bytes past the count are masked off
         if (n > 8) lane_h2 = lane_h2 ^ mix_high(hi & tail_keep(n - 8));
         if (n > 0) lane_h1 = lane_h1 ^ mix_low(lo & tail_keep(n));
      end
      // saturating length; 2^27 blocks are out of reach here, kept for completeness
      sum = {1'b0, key_bytes} + 32'(n);
      if (sum > {1'b0, mm3_pkg::COUNT_MAX}) begin
         sum = {1'b0, mm3_pkg::COUNT_MAX};
         key_capped = 1'b1;
      end
      key_bytes = sum[mm3_pkg::COUNT_W-1:0];
      if (last) begin
         len64 = {{(64 - mm3_pkg::COUNT_W){1'b0}}, key_bytes};
         f1 = lane_h1 ^ len64;
         f2 = lane_h2 ^ len64;
         f1 = f1 + f2;
         f2 = f2 + f1;
         f1 = fmix64(f1);
         f2 = fmix64(f2);
         f1 = f1 + f2;
         f2 = f2 + f1;
         h.first  = f1;
         h.second = f2;
         h.ovf    = key_capped;
         hash_due.push_back(pinned ? pin : h);
         lane_h1    = {32'd0, seed_now};
         lane_h2    = {32'd0, seed_now};
         key_bytes  = '0;
         key_capped = 1'b0;
      end
   endtask

   // Watch all three channels at each edge
   always @(posedge clock) begin
      hash_type got;
      hash_type want;
      if (!reset) begin
         cycles = cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            // results first, so a stray result is never matched by a word taken this edge
            if (rsp_tvalid && rsp_tready) begin
               got.first  = rsp_tdata[63:0];
               got.second = rsp_tdata[127:64];
               got.ovf    = rsp_tuser;
               if (hash_due.size() == 0) begin
                  mismatches++;
                  $display("%0t: expected no hash, got %h %h ovf %b", $time,
                           got.first, got.second, got.ovf);
               end else begin
                  want = hash_due.pop_front();
                  if (got.first !== want.first || got.second !== want.second ||
                      got.ovf !== want.ovf) begin
                     mismatches++;
                     $display("%0t: expected %h %h ovf %b, got %h %h ovf %b", $time,
                              want.first, want.second, want.ovf,
                              got.first, got.second, got.ovf);
                  end
               end
            end
            if (req_tvalid && req_tready)
               absorb_word(req_tdata[63:0], req_tdata[127:64], req_tdata[132:128],
                           req_tlast, word_pin, word_pin_hash);
            if (csr_valid && csr_ready)
               seed_now = csr_data;
         end
      end
   end

   // Result side: random stalls, plus one long hold on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_cycles > 0) begin
            stall = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one key word and hold it until taken
   task automatic offer_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] nbytes,
                             logic last, logic pinned, hash_type pin);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= {3'b000, nbytes, hi, lo};
      req_tlast     <= last;
      word_pin      <= pinned;
      word_pin_hash <= pin;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending, wait for every hash, then let an unfinished word drain
   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hash_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_seed(logic [mm3_pkg::SEED_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      row_type     plan [PLAN_ROWS];
      int          sent;
      int          phase;
      int          budget;
      int          body;
      int          extra;
      logic [4:0]  tail;
      logic [mm3_pkg::SEED_W-1:0] seed_pick;

      // Directed plan: empty keys over zero lanes hash to zero
      plan = '{
         '{ROW_WORD, 64'h0, 64'h0, 5'd0, 1'b1, 1'b1, '0},
         '{ROW_WORD, 64'h0, 64'h0, 5'd16, 1'b1, 1'b0, '0},
         '{ROW_WORD, '1, '1, 5'd16, 1'b0, 1'b0, '0},
         '{ROW_WORD, '1, '1, 5'd0, 1'b0, 1'b0, '0},     // count ignored when not last
         '{ROW_WORD, '1, '1, 5'd31, 1'b1, 1'b0, '0},    // count above sixteen
         '{ROW_WORD, '1, '1, 5'd17, 1'b1, 1'b0, '0},
         '{ROW_WORD, '1, '1, 5'd1, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd7, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd8, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd9, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd15, 1'b1, 1'b0, '0},
         '{ROW_SEED, 64'hffffffff, 64'h0, 5'd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, 64'h0, 64'h0, 5'd0, 1'b1, 1'b1, '0},  // lanes still from old seed
         '{ROW_WORD, 64'h0, 64'h0, 5'd0, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0, 1'b0, '0},
         '{ROW_SEED, 64'h12345678, 64'h0, 5'd0, 1'b0, 1'b0, '0},  // seed change inside a key
         '{ROW_WORD, '1, '1, 5'd12, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0, 64'h0, 5'd0, 1'b1, 1'b0, '0},
         '{ROW_SEED, 64'h0, 64'h0, 5'd0, 1'b0, 1'b0, '0},
         '{ROW_WORD, '1, '1, 5'd5, 1'b0, 1'b0, '0},
         '{ROW_WORD, 64'h0, 64'h0, 5'd31, 1'b0, 1'b0, '0},
         '{ROW_WORD, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd16, 1'b1, 1'b0, '0},
         '{ROW_WORD, 64'h0, 64'h0, 5'd0, 1'b1, 1'b1, '0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SEED)
            write_seed(plan[i].lo[mm3_pkg::SEED_W-1:0]);
         else
            offer_word(plan[i].lo, plan[i].hi, plan[i].nbytes, plan[i].last,
                       plan[i].pinned, plan[i].pin);
      end

      // Random keys in phases, a new seed at the start of each
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         case (phase % 5)
            0:       seed_pick = '0;
            1:       seed_pick = '1;
            default: seed_pick = $urandom();
         endcase
         write_seed(seed_pick);
         no_gaps = ($urandom_range(0, 3) == 0);

         // Back-pressure: hold results off while short keys keep coming
         if (phase == 3) begin
            no_gaps = 1'b1;
            long_hold_cycles = 400;
            repeat (10) begin
               offer_word(rand_word(), rand_word(), 5'($urandom_range(0, 16)), 1'b1,
                          1'b0, '0);
               sent++;
            end
            settle_block();
            no_gaps = ($urandom_range(0, 1) == 0);
         end

         budget = $urandom_range(60, 140);
         while (budget > 0) begin
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12)
                                               : $urandom_range(0, 3);
            repeat (body)
               offer_word(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0,
                          1'b0, '0);
            tail = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
            offer_word(rand_word(), rand_word(), tail, 1'b1, 1'b0, '0);
            sent   += body + 1;
            budget -= body + 1;
         end

         // Sometimes leave a key open so the next seed lands mid-key
         if ($urandom_range(0, 2) == 0) begin
            extra = $urandom_range(1, 2);
            repeat (extra)
               offer_word(rand_word(), rand_word(), 5'($urandom_range(0, 31)), 1'b0,
                          1'b0, '0);
            sent += extra;
         end
         phase++;
      end

      settle_block();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/core/mm3_pkg.sv
rtl/core/mm3_datapath.sv
rtl/core/mm3_ctrl.sv
rtl/core/murmur3_x64_128_hash.sv
tb/sv/murmur3_x64_128_hash_test.sv
